// ===== rtl/vrot_pkg.sv =====
`timescale 1ns / 1ps

package vrot_pkg;

   // coordinate format, signed q16.16
   localparam int COORD_BITS = 32;
   localparam int ANGLE_BITS = 16;

   // fractional bits kept in the rounded sine and cosine
   localparam int TRIG_FRAC  = ((62 - COORD_BITS) < 30) ? (62 - COORD_BITS) : 30;
   localparam int TRIG_SHIFT = 30 - TRIG_FRAC;
   localparam int TRIG_W     = TRIG_FRAC + 2;

   // cordic vector in q2.30 with headroom, angle residual in 2^-32 turn
   localparam int VEC_W = 34;
   localparam int ANG_W = 34;
   localparam int MAX_STAGES = 32;

   // product and sum widths of the final rotation
   localparam int PROD_W = COORD_BITS + TRIG_W;
   localparam int SUM_W  = PROD_W + 1;

   localparam logic signed [VEC_W-1:0] GAIN_Q30 = VEC_W'(652032874);

   // axis select codes
   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   // arctangent of 2^-i in 2^-32 turn, rounded to nearest
   localparam logic signed [ANG_W-1:0] ATAN_TURNS [MAX_STAGES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1, 1, 0
   };

   typedef struct packed {
      logic [1:0]                   kind;
      logic signed [COORD_BITS-1:0] in_x;
      logic signed [COORD_BITS-1:0] in_y;
      logic signed [COORD_BITS-1:0] in_z;
      logic [ANGLE_BITS-1:0]        turn_angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
   } rsp_type;

   // point and control carried alongside the trig pipeline
   typedef struct packed {
      logic [1:0]                   kind;
      logic                         flip;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic signed [COORD_BITS-1:0] pz;
   } item_type;

endpackage

// ===== rtl/vrot_front.sv =====
`timescale 1ns / 1ps

module vrot_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  vrot_pkg::req_type          req_data,
   output logic                       stall_up,
   output logic                       valid_out,
   output vrot_pkg::item_type         item_out,
   output logic signed [vrot_pkg::ANG_W-1:0] angle_out,
   input  logic                       stall_dn
);

   import vrot_pkg::*;

   logic                   valid_ff;
   item_type               item_ff, item_in;
   logic signed [ANG_W-1:0] angle_ff, angle_in;
   logic                   hold;
   logic [ANGLE_BITS-1:0]  folded;

   // quadrants two and three: remove a half turn (toggle of the top bit)
   always_comb begin
      item_in.kind = req_data.kind;
      item_in.px   = req_data.in_x;
      item_in.py   = req_data.in_y;
      item_in.pz   = req_data.in_z;
      item_in.flip = req_data.turn_angle[ANGLE_BITS-1] ^ req_data.turn_angle[ANGLE_BITS-2];
      folded       = req_data.turn_angle;
      if (item_in.flip) begin
         folded[ANGLE_BITS-1] = ~req_data.turn_angle[ANGLE_BITS-1];
      end
      angle_in = {{(ANG_W-ANGLE_BITS-16){folded[ANGLE_BITS-1]}}, folded, 16'b0};
   end

   assign hold = valid_ff & stall_dn;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         item_ff  <= item_in;
         angle_ff <= angle_in;
      end
   end

   assign stall_up  = hold;
   assign valid_out = valid_ff;
   assign item_out  = item_ff;
   assign angle_out = angle_ff;

endmodule

// ===== rtl/vrot_cordic.sv =====
`timescale 1ns / 1ps

module vrot_cordic #(
   parameter int STAGES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_in,
   input  vrot_pkg::item_type                item_in,
   input  logic signed [vrot_pkg::ANG_W-1:0] angle_in,
   output logic                              stall_up,
   output logic                              valid_out,
   output vrot_pkg::item_type                item_out,
   output logic signed [vrot_pkg::VEC_W-1:0] cos_out,
   output logic signed [vrot_pkg::VEC_W-1:0] sin_out,
   input  logic                              stall_dn
);

   import vrot_pkg::*;

   logic [STAGES-1:0]       v_ff;
   logic [STAGES-1:0]       v_src;
   logic [STAGES-1:0]       hold;
   item_type                it_ff  [STAGES];
   item_type                it_src [STAGES];
   logic signed [VEC_W-1:0] x_ff   [STAGES];
   logic signed [VEC_W-1:0] y_ff   [STAGES];
   logic signed [ANG_W-1:0] z_ff   [STAGES];
   logic signed [VEC_W-1:0] x_src  [STAGES];
   logic signed [VEC_W-1:0] y_src  [STAGES];
   logic signed [ANG_W-1:0] z_src  [STAGES];
   logic signed [VEC_W-1:0] x_in   [STAGES];
   logic signed [VEC_W-1:0] y_in   [STAGES];
   logic signed [ANG_W-1:0] z_in   [STAGES];

   always_comb begin
      // first micro-rotation starts from the gain-compensated unit vector
      v_src[0]  = valid_in;
      it_src[0] = item_in;
      x_src[0]  = GAIN_Q30;
      y_src[0]  = '0;
      z_src[0]  = angle_in;
      for (int i = 1; i < STAGES; i++) begin
         v_src[i]  = v_ff[i-1];
         it_src[i] = it_ff[i-1];
         x_src[i]  = x_ff[i-1];
         y_src[i]  = y_ff[i-1];
         z_src[i]  = z_ff[i-1];
      end
      for (int i = 0; i < STAGES; i++) begin
         if (!z_src[i][ANG_W-1]) begin
            x_in[i] = x_src[i] - (y_src[i] >>> i);
            y_in[i] = y_src[i] + (x_src[i] >>> i);
            z_in[i] = z_src[i] - ATAN_TURNS[i];
         end else begin
            x_in[i] = x_src[i] + (y_src[i] >>> i);
            y_in[i] = y_src[i] - (x_src[i] >>> i);
            z_in[i] = z_src[i] + ATAN_TURNS[i];
         end
      end
      hold[STAGES-1] = v_ff[STAGES-1] & stall_dn;
      for (int i = STAGES - 2; i >= 0; i--) begin
         hold[i] = v_ff[i] & hold[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (!hold[i]) begin
               v_ff[i] <= v_src[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (!hold[i]) begin
            it_ff[i] <= it_src[i];
            x_ff[i]  <= x_in[i];
            y_ff[i]  <= y_in[i];
            z_ff[i]  <= z_in[i];
         end
      end
   end

   assign stall_up  = hold[0];
   assign valid_out = v_ff[STAGES-1];
   assign item_out  = it_ff[STAGES-1];
   assign cos_out   = x_ff[STAGES-1];
   assign sin_out   = y_ff[STAGES-1];

endmodule

// ===== rtl/vrot_mac.sv =====
`timescale 1ns / 1ps

module vrot_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_in,
   input  vrot_pkg::item_type                item_in,
   input  logic signed [vrot_pkg::VEC_W-1:0] cos_in,
   input  logic signed [vrot_pkg::VEC_W-1:0] sin_in,
   output logic                              stall_up,
   output logic                              rsp_valid,
   output vrot_pkg::rsp_type                 rsp_data,
   input  logic                              rsp_stall
);

   import vrot_pkg::*;

   localparam logic signed [VEC_W-1:0] TRIG_RND =
      (TRIG_SHIFT > 0) ? (VEC_W'(1) << (TRIG_SHIFT - 1)) : '0;
   localparam logic signed [SUM_W-1:0] OUT_RND = SUM_W'(1) << (TRIG_FRAC - 1);
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [SUM_W-1:0] r;
      r = v >>> TRIG_FRAC;
      if (r > SAT_HI) begin
         return SAT_HI[COORD_BITS-1:0];
      end else if (r < SAT_LO) begin
         return SAT_LO[COORD_BITS-1:0];
      end
      return r[COORD_BITS-1:0];
   endfunction

   // stage a: sign fold and rounding of sine and cosine
   logic                     a_v_ff;
   item_type                 a_item_ff;
   logic signed [TRIG_W-1:0] a_cos_ff, a_cos_in;
   logic signed [TRIG_W-1:0] a_sin_ff, a_sin_in;
   logic signed [VEC_W-1:0]  cos_n, sin_n, cos_r, sin_r;

   // stage b: four products
   logic                     b_v_ff;
   item_type                 b_item_ff;
   logic signed [COORD_BITS-1:0] sel_a, sel_b;
   logic signed [PROD_W-1:0] ac_ff, bs_ff, bc_ff, as_ff;
   logic signed [PROD_W-1:0] ac_in, bs_in, bc_in, as_in;

   // stage c: sums with rounding offset
   logic                     c_v_ff;
   item_type                 c_item_ff;
   logic signed [SUM_W-1:0]  acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;

   // stage d: shift, clamp and reassembly into the response register
   logic                     d_v_ff;
   rsp_type                  d_rsp_ff, d_rsp_in;
   logic signed [COORD_BITS-1:0] rot_a, rot_b;

   logic a_hold, b_hold, c_hold, d_hold;

   assign d_hold = d_v_ff & rsp_stall;
   assign c_hold = c_v_ff & d_hold;
   assign b_hold = b_v_ff & c_hold;
   assign a_hold = a_v_ff & b_hold;

   always_comb begin
      cos_n    = item_in.flip ? -cos_in : cos_in;
      sin_n    = item_in.flip ? -sin_in : sin_in;
      cos_r    = (cos_n + TRIG_RND) >>> TRIG_SHIFT;
      sin_r    = (sin_n + TRIG_RND) >>> TRIG_SHIFT;
      a_cos_in = cos_r[TRIG_W-1:0];
      a_sin_in = sin_r[TRIG_W-1:0];
   end

   always_comb begin
      unique case (a_item_ff.kind)
         AXIS_X: begin
            sel_a = a_item_ff.py;
            sel_b = a_item_ff.pz;
         end
         AXIS_Y: begin
            sel_a = a_item_ff.px;
            sel_b = a_item_ff.pz;
         end
         default: begin
            sel_a = a_item_ff.px;
            sel_b = a_item_ff.py;
         end
      endcase
      ac_in = PROD_W'(sel_a) * PROD_W'(a_cos_ff);
      bs_in = PROD_W'(sel_b) * PROD_W'(a_sin_ff);
      bc_in = PROD_W'(sel_b) * PROD_W'(a_cos_ff);
      as_in = PROD_W'(sel_a) * PROD_W'(a_sin_ff);
   end

   always_comb begin
      acc_a_in = SUM_W'(ac_ff) - SUM_W'(bs_ff) + OUT_RND;
      acc_b_in = SUM_W'(bc_ff) + SUM_W'(as_ff) + OUT_RND;
   end

   always_comb begin
      rot_a = sat_coord(acc_a_ff);
      rot_b = sat_coord(acc_b_ff);
      unique case (c_item_ff.kind)
         AXIS_X: begin
            d_rsp_in.out_x = c_item_ff.px;
            d_rsp_in.out_y = rot_a;
            d_rsp_in.out_z = rot_b;
         end
         AXIS_Y: begin
            d_rsp_in.out_x = rot_a;
            d_rsp_in.out_y = c_item_ff.py;
            d_rsp_in.out_z = rot_b;
         end
         AXIS_Z: begin
            d_rsp_in.out_x = rot_a;
            d_rsp_in.out_y = rot_b;
            d_rsp_in.out_z = c_item_ff.pz;
         end
         AXIS_NONE: begin
            d_rsp_in.out_x = c_item_ff.px;
            d_rsp_in.out_y = c_item_ff.py;
            d_rsp_in.out_z = c_item_ff.pz;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (!a_hold) begin
            a_v_ff <= valid_in;
         end
         if (!b_hold) begin
            b_v_ff <= a_v_ff;
         end
         if (!c_hold) begin
            c_v_ff <= b_v_ff;
         end
         if (!d_hold) begin
            d_v_ff <= c_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!a_hold) begin
         a_item_ff <= item_in;
         a_cos_ff  <= a_cos_in;
         a_sin_ff  <= a_sin_in;
      end
      if (!b_hold) begin
         b_item_ff <= a_item_ff;
         ac_ff     <= ac_in;
         bs_ff     <= bs_in;
         bc_ff     <= bc_in;
         as_ff     <= as_in;
      end
      if (!c_hold) begin
         c_item_ff <= b_item_ff;
         acc_a_ff  <= acc_a_in;
         acc_b_ff  <= acc_b_in;
      end
      if (!d_hold) begin
         d_rsp_ff <= d_rsp_in;
      end
   end

   assign stall_up  = a_hold;
   assign rsp_valid = d_v_ff;
   assign rsp_data  = d_rsp_ff;

endmodule

// ===== rtl/vector_axis_rotator_top.sv =====
// vector axis rotator: turns a q16.16 point about the x, y or z axis
// request channel: req_valid, req_data, req_stall; a request is taken at a
//   rising edge with req_valid high and req_stall low
// response channel: rsp_valid, rsp_data, rsp_stall; same rule, rsp_stall
//   driven by the receiver
// the pipe holds one fold stage, one cordic stage per iteration and four
//   rotation stages between acceptance and rsp_valid
// throughput: one request per cycle while no stall backs up, set by the fully
//   pipelined cordic and the registered multiply stage
// axis select three returns the point unchanged through the same stages
// reset: synchronous, active high, empties every stage; nothing else is held
// receiver stall: the response register holds its value, and the stall
//   only backs up as far as the stages that hold requests, so empty stages
//   keep filling and req_stall rises only once the pipe is full behind it
`timescale 1ns / 1ps

module vector_axis_rotator_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  vrot_pkg::req_type req_data,
   output logic              req_stall,
   output logic              rsp_valid,
   output vrot_pkg::rsp_type rsp_data,
   input  logic              rsp_stall
);

   import vrot_pkg::*;

   // front end to cordic
   logic                    fr_valid;
   item_type                fr_item;
   logic signed [ANG_W-1:0] fr_angle;
   logic                    fr_stall;

   // cordic to rotation stages
   logic                    cd_valid;
   item_type                cd_item;
   logic signed [VEC_W-1:0] cd_cos;
   logic signed [VEC_W-1:0] cd_sin;
   logic                    cd_stall;

   // angle fold into a quarter turn either side of zero
   vrot_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .stall_up  (req_stall),
      .valid_out (fr_valid),
      .item_out  (fr_item),
      .angle_out (fr_angle),
      .stall_dn  (fr_stall)
   );

   // one micro-rotation per register stage
   vrot_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (fr_valid),
      .item_in   (fr_item),
      .angle_in  (fr_angle),
      .stall_up  (fr_stall),
      .valid_out (cd_valid),
      .item_out  (cd_item),
      .cos_out   (cd_cos),
      .sin_out   (cd_sin),
      .stall_dn  (cd_stall)
   );

   // trig rounding, products, sums and saturation into the response register
   vrot_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (cd_valid),
      .item_in   (cd_item),
      .cos_in    (cd_cos),
      .sin_in    (cd_sin),
      .stall_up  (cd_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import vrot_pkg::*;

   // cordic stage count of the instance under test
   localparam int ROTATOR_STAGES = 16;
   // cycles with no request or response moving before the run is abandoned
   localparam int STALL_LIMIT    = 3000;
   localparam int RANDOM_REQUESTS = 550;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(32'sh0001_0000);

   // binary angles that sit on the folding boundaries
   localparam logic [ANGLE_BITS-1:0] TURN_QUARTER      = 16'h4000;
   localparam logic [ANGLE_BITS-1:0] TURN_HALF         = 16'h8000;
   localparam logic [ANGLE_BITS-1:0] TURN_THREE_QUARTS = 16'hC000;

   // scoreboard: predicts each rotated point and checks responses in order
   class rotation_board;
      rsp_type expected_points[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      // gain-compensated cordic in rotation mode, angle folded to +-1/4 turn
      function void trig_of_angle(input logic [ANGLE_BITS-1:0] angle,
                                  output longint cos_v, output longint sin_v);
         longint resid, vx, vy, vz, dx, dy;
         bit     flip;
         int     shift;
         resid = longint'($signed(angle));
         flip  = 1'b0;
         if (resid >= 16384) begin
            resid -= 32768;
            flip = 1'b1;
         end else if (resid < -16384) begin
            resid += 32768;
            flip = 1'b1;
         end
         vz = resid * 65536;
         vx = longint'(GAIN_Q30);
         vy = 0;
         for (int i = 0; i < ROTATOR_STAGES && i < MAX_STAGES; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vz >= 0) begin
               vx -= dx;
               vy += dy;
               vz -= longint'(ATAN_TURNS[i]);
            end else begin
               vx += dx;
               vy -= dy;
               vz += longint'(ATAN_TURNS[i]);
            end
         end
         if (flip) begin
            vx = -vx;
            vy = -vy;
         end
         shift = 30 - TRIG_FRAC;
         if (shift > 0) begin
            vx = (vx + (longint'(1) << (shift - 1))) >>> shift;
            vy = (vy + (longint'(1) << (shift - 1))) >>> shift;
         end
         cos_v = vx;
         sin_v = vy;
      endfunction

      function longint round_clamp(longint acc);
         longint hi, lo, r;
         hi = (longint'(1) << (COORD_BITS - 1)) - 1;
         lo = -hi - 1;
         r  = (acc + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
         if (r > hi) return hi;
         if (r < lo) return lo;
         return r;
      endfunction

      function rsp_type rotate_point(req_type r);
         longint  pnt[3];
         longint  c, s, a, b;
         int      ia, ib;
         rsp_type o;
         pnt[0] = longint'(r.in_x);
         pnt[1] = longint'(r.in_y);
         pnt[2] = longint'(r.in_z);
         if (r.kind != AXIS_NONE) begin
            case (r.kind)
               AXIS_X: begin
                  ia = 1;
                  ib = 2;
               end
               AXIS_Y: begin
                  ia = 0;
                  ib = 2;
               end
               default: begin
                  ia = 0;
                  ib = 1;
               end
            endcase
            trig_of_angle(r.turn_angle, c, s);
            a = pnt[ia];
            b = pnt[ib];
            pnt[ia] = round_clamp(a * c - b * s);
            pnt[ib] = round_clamp(b * c + a * s);
         end
         o.out_x = pnt[0][COORD_BITS-1:0];
         o.out_y = pnt[1][COORD_BITS-1:0];
         o.out_z = pnt[2][COORD_BITS-1:0];
         return o;
      endfunction

      function void note_request(req_type r);
         expected_points.push_back(rotate_point(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_points.size() == 0) begin
            $error("response with no request outstanding: %0d %0d %0d",
                   got.out_x, got.out_y, got.out_z);
            errors++;
            return;
         end
         want = expected_points.pop_front();
         if (got.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, got.out_x);
            errors++;
         end
         if (got.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, got.out_y);
            errors++;
         end
         if (got.out_z !== want.out_z) begin
            $error("out_z: expected %0d, got %0d", want.out_z, got.out_z);
            errors++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   rotation_board board = new();
   int            idle_cycles = 0;

   always #5 clock = ~clock;

   vector_axis_rotator_top #(
      .CORDIC_STAGES(ROTATOR_STAGES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // monitor and watchdog: everything sampled is the value from before the edge
   always @(posedge clock) begin
      bit req_taken, rsp_taken;
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (req_taken) board.note_request(req_data);
      if (rsp_taken) board.check_response(rsp_data);
      // the watchdog only counts cycles in which neither channel moves
      if (reset || req_taken || rsp_taken) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic req_type make_request(logic [1:0] kind,
                                            logic signed [COORD_BITS-1:0] x,
                                            logic signed [COORD_BITS-1:0] y,
                                            logic signed [COORD_BITS-1:0] z,
                                            logic [ANGLE_BITS-1:0] angle);
      req_type r;
      r.kind       = kind;
      r.in_x       = x;
      r.in_y       = y;
      r.in_z       = z;
      r.turn_angle = angle;
      return r;
   endfunction

   // coordinates lean towards the range ends and small values, the rest full width
   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3: return COORD_BITS'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [ANGLE_BITS-1:0] pick_angle();
      case ($urandom_range(0, 15))
         0: return TURN_QUARTER;
         1: return TURN_HALF;
         2: return TURN_THREE_QUARTS;
         3: return TURN_QUARTER - 1'b1;
         4: return TURN_THREE_QUARTS - 1'b1;
         5: return '1;
         6: return '0;
         default: return ANGLE_BITS'($urandom);
      endcase
   endfunction

   function automatic req_type random_request();
      logic [1:0] kind;
      kind = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
      return make_request(kind, pick_coord(), pick_coord(), pick_coord(), pick_angle());
   endfunction

   // gap before a request: mode 0 streams back to back, otherwise mostly short gaps
   function automatic int pick_gap(int mode);
      int roll;
      if (mode == 0) return 0;
      roll = $urandom_range(0, 19);
      if (roll < 12) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offers one request after the gap and returns at the edge that takes it
   task automatic send_request(req_type r, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // receiver back-pressure: clear stretches, random stalling and the odd long hold
   initial begin
      int pct;
      forever begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(5, 60)) @(posedge clock);
            end
            3: begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end
            default: begin
               pct = $urandom_range(10, 60);
               repeat ($urandom_range(5, 60)) begin
                  rsp_stall <= ($urandom_range(0, 99) < pct);
                  @(posedge clock);
               end
            end
         endcase
      end
   end

   // stimulus: directed corner points first, then bursts of random requests
   initial begin
      req_type directed[$];
      int      sent, burst, mode;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero angle about x, then the folding boundaries
      directed.push_back(make_request(AXIS_X, COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE, '0));
      directed.push_back(make_request(AXIS_Y, COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE,
                                      TURN_QUARTER));
      directed.push_back(make_request(AXIS_Z, COORD_ONE, 2 * COORD_ONE, 3 * COORD_ONE,
                                      TURN_HALF));
      directed.push_back(make_request(AXIS_X, COORD_ONE, -COORD_ONE, 5 * COORD_ONE,
                                      TURN_THREE_QUARTS));
      directed.push_back(make_request(AXIS_Y, -COORD_ONE, COORD_ONE, 7 * COORD_ONE,
                                      TURN_THREE_QUARTS - 1'b1));
      directed.push_back(make_request(AXIS_Z, 4 * COORD_ONE, -COORD_ONE, COORD_ONE,
                                      TURN_QUARTER - 1'b1));
      directed.push_back(make_request(AXIS_Z, COORD_ONE, COORD_ONE, COORD_ONE, '1));
      // no-rotation select passes the point through, extremes included
      directed.push_back(make_request(AXIS_NONE, COORD_MAX, COORD_MIN, COORD_MAX, 16'd12345));
      directed.push_back(make_request(AXIS_NONE, '0, '0, '0, '0));
      // eighth turns on full-scale points push the result past the range ends, then other angles follow
      directed.push_back(make_request(AXIS_Z, COORD_MAX, COORD_MAX, '0, 16'h2000));
      directed.push_back(make_request(AXIS_Z, COORD_MIN, COORD_MIN, '0, 16'h2000));
      directed.push_back(make_request(AXIS_X, '0, COORD_MIN, COORD_MIN, 16'h6000));
      directed.push_back(make_request(AXIS_Y, COORD_MIN, '0, COORD_MAX, '1));
      // half turn of the most negative value saturates high, then zero angle and a zero point
      directed.push_back(make_request(AXIS_Z, COORD_MIN, COORD_MAX, COORD_MAX, TURN_HALF));
      directed.push_back(make_request(AXIS_X, COORD_MIN, COORD_MIN, COORD_MIN, TURN_HALF));
      directed.push_back(make_request(AXIS_Z, COORD_MIN, COORD_MIN, COORD_MIN, '0));
      directed.push_back(make_request(AXIS_Y, '0, '0, '0, TURN_QUARTER));
      // one-lsb coordinates exercise the rounding, then full-scale points at other angles
      directed.push_back(make_request(AXIS_X, 32'sd1, -32'sd1, 32'sd1, 16'h2000));
      directed.push_back(make_request(AXIS_Z, COORD_MAX, '0, '0, 16'h1000));
      directed.push_back(make_request(AXIS_Y, COORD_MAX, COORD_MIN, COORD_MIN, 16'hA000));

      foreach (directed[i]) send_request(directed[i], pick_gap(1));

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 40);
         mode  = $urandom_range(0, 3);
         repeat (burst) begin
            send_request(random_request(), pick_gap(mode));
            sent++;
         end
      end
      req_valid <= 1'b0;

      // drain, then give the pipe time to show any stray response
      while (board.pending() != 0) @(posedge clock);
      repeat (ROTATOR_STAGES + 10) @(posedge clock);

      if (board.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ===== vector_axis_rotator_top.f =====
rtl/vrot_pkg.sv
rtl/vrot_front.sv
rtl/vrot_cordic.sv
rtl/vrot_mac.sv
rtl/vector_axis_rotator_top.sv
tb/testbench.sv
